### hw/rtl/slm_pkg.sv
// Shared constants and types for the sorted list merge block.
package slm_pkg;

  // Widths fixed by the data format.
  localparam int DATA_W = 32;
  localparam int FUNC_W = 2;

  // Default number of entries per list.
  localparam int DEFAULT_LIST_DEPTH = 32;

  // Command codes.
  localparam logic [FUNC_W-1:0] FUNC_LOAD_A = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_B = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_MERGE  = 2'd2;

  // Sequencer states.
  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

endpackage

### hw/rtl/sorted_list_merge.sv
// Top level of the sorted list merge block: two list stores and the sequencer.
// Loads: one per cycle while no merge runs, busy stays low; a load into a full list is dropped.
// Merge: an accepted merge enters the emit state and strobe is registered from it; one beat
// per cycle from the compare on the two memory read ports; busy is high while emitting.
// Results cannot be stalled; each beat is shown for one cycle with strobe.
// Reset clears the counts and the sequencer; list memory contents are not cleared.
module sorted_list_merge #(
  parameter int LIST_DEPTH = slm_pkg::DEFAULT_LIST_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [slm_pkg::FUNC_W-1:0]        func,
  input  logic signed [slm_pkg::DATA_W-1:0] value,
  output logic                              strobe,
  output logic signed [slm_pkg::DATA_W-1:0] merged_value,
  output logic                              last_item
);

  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW = $clog2(LIST_DEPTH + 1);

  logic                              a_we, b_we;
  logic [AW-1:0]                     a_waddr, b_waddr, a_raddr, b_raddr;
  logic signed [slm_pkg::DATA_W-1:0] a_rdata, b_rdata;

  // List A store.
  slm_list_mem #(
    .LIST_DEPTH (LIST_DEPTH),
    .AW         (AW)
  ) u_mem_a (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (value),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  // List B store.
  slm_list_mem #(
    .LIST_DEPTH (LIST_DEPTH),
    .AW         (AW)
  ) u_mem_b (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (value),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  // Sequencer.
  slm_merge_ctrl #(
    .LIST_DEPTH (LIST_DEPTH),
    .AW         (AW),
    .CW         (CW)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .func         (func),
    .busy         (busy),
    .a_we         (a_we),
    .a_waddr      (a_waddr),
    .a_raddr      (a_raddr),
    .a_rdata      (a_rdata),
    .b_we         (b_we),
    .b_waddr      (b_waddr),
    .b_raddr      (b_raddr),
    .b_rdata      (b_rdata),
    .strobe       (strobe),
    .merged_value (merged_value),
    .last_item    (last_item)
  );

endmodule

### hw/rtl/slm_list_mem.sv
// Single list store: one write port, one read port with registered data.
module slm_list_mem #(
  parameter int LIST_DEPTH = slm_pkg::DEFAULT_LIST_DEPTH,
  parameter int AW         = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic [AW-1:0]                     waddr,
  input  logic signed [slm_pkg::DATA_W-1:0] wdata,
  input  logic [AW-1:0]                     raddr,
  output logic signed [slm_pkg::DATA_W-1:0] rdata
);

  logic signed [slm_pkg::DATA_W-1:0] mem [2**AW];

  // Write side.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read side, data registered.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/slm_merge_ctrl.sv
// Load and merge sequencer: list counts, read pointers, compare and result register.
module slm_merge_ctrl #(
  parameter int LIST_DEPTH = slm_pkg::DEFAULT_LIST_DEPTH,
  parameter int AW         = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1,
  parameter int CW         = $clog2(LIST_DEPTH + 1)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [slm_pkg::FUNC_W-1:0]        func,
  output logic                              busy,
  output logic                              a_we,
  output logic [AW-1:0]                     a_waddr,
  output logic [AW-1:0]                     a_raddr,
  input  logic signed [slm_pkg::DATA_W-1:0] a_rdata,
  output logic                              b_we,
  output logic [AW-1:0]                     b_waddr,
  output logic [AW-1:0]                     b_raddr,
  input  logic signed [slm_pkg::DATA_W-1:0] b_rdata,
  output logic                              strobe,
  output logic signed [slm_pkg::DATA_W-1:0] merged_value,
  output logic                              last_item
);

  slm_pkg::state_t state, state_next;

  logic [CW-1:0] cnt_a, cnt_b;
  logic [CW-1:0] ia, ib, ia_next, ib_next;
  logic [CW:0]   left;
  logic [CW:0]   total;
  logic          accept;
  logic          merge_go;
  logic          take_a;
  logic          emit;
  logic          last;

  assign accept = start && !busy;
  assign total  = {1'b0, cnt_a} + {1'b0, cnt_b};
  assign merge_go = accept && (func == slm_pkg::FUNC_MERGE) && (total != '0);

  // Loads append at the current count unless the list is full.
  assign a_we    = accept && (func == slm_pkg::FUNC_LOAD_A) && (cnt_a < CW'(LIST_DEPTH));
  assign b_we    = accept && (func == slm_pkg::FUNC_LOAD_B) && (cnt_b < CW'(LIST_DEPTH));
  assign a_waddr = cnt_a[AW-1:0];
  assign b_waddr = cnt_b[AW-1:0];

  // The A head wins only when strictly less, so ties come from B first.
  assign take_a = (ia < cnt_a) && ((ib >= cnt_b) || (a_rdata < b_rdata));
  assign last   = (left == (CW+1)'(1));

  // Next state, pointer advance and read addresses.
  always_comb begin
    state_next = state;
    busy       = 1'b0;
    emit       = 1'b0;
    ia_next    = ia;
    ib_next    = ib;
    unique case (state)
      slm_pkg::ST_IDLE: begin
        if (merge_go) begin
          state_next = slm_pkg::ST_EMIT;
        end
      end
      slm_pkg::ST_EMIT: begin
        busy = 1'b1;
        emit = 1'b1;
        if (take_a) begin
          ia_next = ia + CW'(1);
        end else begin
          ib_next = ib + CW'(1);
        end
        if (last) begin
          state_next = slm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = slm_pkg::ST_IDLE;
      end
    endcase
  end

  // Pointers past the end alias a harmless entry; that head is never chosen.
  assign a_raddr = ia_next[AW-1:0];
  assign b_raddr = ib_next[AW-1:0];

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= slm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Counts, pointers and remaining-result counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_a <= '0;
      cnt_b <= '0;
      ia    <= '0;
      ib    <= '0;
      left  <= '0;
    end else begin
      if (a_we) begin
        cnt_a <= cnt_a + CW'(1);
      end
      if (b_we) begin
        cnt_b <= cnt_b + CW'(1);
      end
      if (merge_go) begin
        left <= total;
      end
      if (emit) begin
        left <= left - (CW+1)'(1);
        if (last) begin
          cnt_a <= '0;
          cnt_b <= '0;
          ia    <= '0;
          ib    <= '0;
        end else begin
          ia <= ia_next;
          ib <= ib_next;
        end
      end
    end
  end

  // Result register: one beat per emitted value.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      merged_value <= take_a ? a_rdata : b_rdata;
      last_item    <= last;
    end
  end

  // Read pointers never run past their list.
  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    (state == slm_pkg::ST_EMIT) |-> (ia <= cnt_a) && (ib <= cnt_b))
    else $error("merge pointer beyond list count");

  // Remaining results match what is left in both lists.
  a_left_match: assert property (@(posedge clk) disable iff (rst)
    (state == slm_pkg::ST_EMIT) |->
      (left == ({1'b0, cnt_a} - {1'b0, ia}) + ({1'b0, cnt_b} - {1'b0, ib})))
    else $error("remaining count out of step with pointers");

  // The final beat of a run is followed by a quiet cycle.
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    strobe && last_item |=> !strobe)
    else $error("result beat after the final one");

  // A merge with values loaded starts emitting.
  a_merge_starts: assert property (@(posedge clk) disable iff (rst)
    merge_go |=> (state == slm_pkg::ST_EMIT) && busy)
    else $error("merge accepted but not started");

endmodule
